// File: rtl/core/publish_interval_scheduler_defines.svh
// Assertion macros shared by the publish interval scheduler checkers.
`ifndef PUBLISH_INTERVAL_SCHEDULER_DEFINES_SVH
`define PUBLISH_INTERVAL_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PIS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("publish interval scheduler check failed");

// Next-cycle implication, checked during reset too.
`define PIS_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("publish interval scheduler check failed");

`endif

// File: rtl/core/pis_pkg.sv
// Types and constants of the publish interval scheduler.
package pis_pkg;

   typedef enum logic [1:0] {
      OP_REQUEST = 2'd0,
      OP_DONE    = 2'd1,
      OP_DELAY   = 2'd2,
      OP_QUERY   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_WAIT    = 2'd0,
      KIND_PUBLISH = 2'd1,
      KIND_BLOCK   = 2'd2
   } kind_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [62:0] now_time_us;
      logic [31:0] backoff_ms;
      logic        link_up;
   } req_type;

   typedef struct packed {
      logic        do_publish;
      logic        do_block;
      logic [31:0] wait_ms;
   } rsp_type;

   localparam logic [31:0] IDLE_WAIT_MS = 32'd200;
   localparam logic [31:0] WAIT_MS_MAX  = 32'hFFFF_FFFF;
   localparam logic [9:0]  US_PER_MS    = 10'd1000;
   localparam logic [19:0] US_PER_S     = 20'd1000000;
   localparam logic [62:0] OFFLINE_US   = 63'd1000000;
   localparam logic [62:0] TIME_MAX     = 63'h7FFF_FFFF_FFFF_FFFF;
   // spans at or above 1000 * 2^32 us saturate the wait
   localparam logic [62:0] SAT_SPAN_US  = 63'd4294967296000;
   // floor(2^46 / 125): quotient estimate is exact or one low
   localparam logic [39:0] RECIP_125    = 40'd562949953421;
   localparam logic [6:0]  DIV_125      = 7'd125;

endpackage

// File: rtl/core/publish_interval_scheduler.sv
// Publish interval scheduler: event decode, schedule state and wait computation.
// Query results pass the input register, stages s1 to s4 and the result register.
// Throughput: one event per cycle; the input stalls only when every stage
// and the result register are full and the result is not taken.
// The span-to-milliseconds step is a three-stage reciprocal divide by 1000.
// Synchronous reset clears the interval, schedule state and the stage valid flags.
module publish_interval_scheduler (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pis_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pis_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [22:0]      csr_wr_data
);
   import pis_pkg::*;

   function automatic logic [62:0] sat_add63(input logic [62:0] a, input logic [62:0] b);
      logic [63:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[63] ? TIME_MAX : s[62:0];
   endfunction

   function automatic logic [62:0] max63(input logic [62:0] a, input logic [62:0] b);
      return (a > b) ? a : b;
   endfunction

   logic [42:0] interval_us_ff;
   logic [62:0] last_pub_ff, last_pub_in;
   logic [62:0] retry_ff, retry_in;
   logic        manual_ff, manual_in;

   logic        s0_valid_ff, s0_link_ff;
   opcode_type  s0_op_ff;
   logic [62:0] s0_now_ff;
   logic [41:0] s0_dly_us_ff;

   logic        s1_valid_ff, s1_valid_in;
   kind_type    s1_kind_ff, s1_kind_in;
   logic [62:0] s1_target_ff, s1_target_in, s1_now_ff;

   logic        s2_valid_ff;
   kind_type    s2_kind_ff;
   logic [62:0] s2_span_ff, s2_span_in;
   logic [63:0] s2_diff;

   logic        s3_valid_ff, s3_use_div_ff, s3_use_div_in;
   kind_type    s3_kind_ff;
   logic [31:0] s3_fixed_ms_ff, s3_fixed_ms_in;
   logic [38:0] s3_y_ff, s3_y_in;
   logic [19:0] s3_yh, s3_yl;
   logic [39:0] s3_pp_hh_ff, s3_pp_hl_ff, s3_pp_lh_ff, s3_pp_ll_ff;

   logic        s4_valid_ff, s4_use_div_ff;
   kind_type    s4_kind_ff;
   logic [31:0] s4_fixed_ms_ff, s4_q_ff;
   logic [38:0] s4_y_ff;
   logic [40:0] s4_mid;
   logic [79:0] s4_sum;

   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic [39:0] rs_qx125, rs_rem;
   logic [31:0] rs_q;

   logic        s0_rdy, s1_rdy, s2_rdy, s3_rdy, s4_rdy, rsp_rdy, state_upd;
   logic [62:0] cand_dly, cand_off, next_due, retry_off;
   logic        enabled, due;

   assign rsp_rdy   = !rsp_valid_ff || rsp_ready;
   assign s4_rdy    = !s4_valid_ff || rsp_rdy;
   assign s3_rdy    = !s3_valid_ff || s4_rdy;
   assign s2_rdy    = !s2_valid_ff || s3_rdy;
   assign s1_rdy    = !s1_valid_ff || s2_rdy;
   assign s0_rdy    = !s0_valid_ff || s1_rdy;
   assign req_ready = s0_rdy;
   assign state_upd = s0_valid_ff && s1_rdy;

   // configuration register, kept in microseconds
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_us_ff <= '0;
      end else if (csr_wr_en) begin
         interval_us_ff <= 43'(csr_wr_data) * 43'(US_PER_S);
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_rdy) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_rdy) begin
         s0_op_ff     <= req_data.opcode;
         s0_now_ff    <= req_data.now_time_us;
         s0_dly_us_ff <= 42'(req_data.backoff_ms) * 42'(US_PER_MS);
         s0_link_ff   <= req_data.link_up;
      end
   end

   // event decode and schedule state update
   assign cand_dly  = sat_add63(s0_now_ff, {21'b0, s0_dly_us_ff});
   assign cand_off  = sat_add63(s0_now_ff, OFFLINE_US);
   assign next_due  = sat_add63(last_pub_ff, {20'b0, interval_us_ff});
   assign retry_off = max63(retry_ff, cand_off);
   assign enabled   = interval_us_ff != '0;
   assign due       = manual_ff || (last_pub_ff == '0) || (s0_now_ff >= next_due);

   always_comb begin
      last_pub_in  = last_pub_ff;
      retry_in     = retry_ff;
      manual_in    = manual_ff;
      s1_valid_in  = 1'b0;
      s1_kind_in   = KIND_WAIT;
      s1_target_in = s0_now_ff;
      case (s0_op_ff)
         OP_REQUEST: begin
            manual_in = 1'b1;
         end
         OP_DONE: begin
            last_pub_in = s0_now_ff;
            retry_in    = '0;
            manual_in   = 1'b0;
         end
         OP_DELAY: begin
            retry_in = max63(retry_ff, cand_dly);
         end
         OP_QUERY: begin
            s1_valid_in = 1'b1;
            if (!s0_link_ff) begin
               retry_in     = retry_off;
               s1_target_in = retry_off;
            end else if (!enabled && !manual_ff) begin
               s1_kind_in = KIND_BLOCK;
            end else if (!due) begin
               s1_target_in = max63(next_due, retry_ff);
            end else if ((retry_ff > s0_now_ff) && !manual_ff) begin
               s1_target_in = retry_ff;
            end else begin
               s1_kind_in = KIND_PUBLISH;
               manual_in  = 1'b0;
            end
         end
         default: begin
            s1_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_pub_ff <= '0;
         retry_ff    <= '0;
         manual_ff   <= 1'b0;
      end else if (state_upd) begin
         last_pub_ff <= last_pub_in;
         retry_ff    <= retry_in;
         manual_ff   <= manual_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_rdy) begin
         s1_valid_ff <= s0_valid_ff && s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_rdy) begin
         s1_kind_ff   <= s1_kind_in;
         s1_target_ff <= s1_target_in;
         s1_now_ff    <= s0_now_ff;
      end
   end

   // remaining span, zero when the target has passed
   assign s2_diff    = {1'b0, s1_target_ff} - {1'b0, s1_now_ff};
   assign s2_span_in = s2_diff[63] ? '0 : s2_diff[62:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_rdy) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_rdy) begin
         s2_kind_ff <= s1_kind_ff;
         s2_span_ff <= s2_span_in;
      end
   end

   // classify span and form partial products of span/8 times the reciprocal
   always_comb begin
      s3_use_div_in  = 1'b0;
      s3_fixed_ms_in = '0;
      if (s2_kind_ff == KIND_WAIT) begin
         if (s2_span_ff == '0) begin
            s3_fixed_ms_in = IDLE_WAIT_MS;
         end else if (s2_span_ff >= SAT_SPAN_US) begin
            s3_fixed_ms_in = WAIT_MS_MAX;
         end else begin
            s3_use_div_in = 1'b1;
         end
      end
   end

   assign s3_y_in = s2_span_ff[41:3];
   assign s3_yh   = {1'b0, s3_y_in[38:20]};
   assign s3_yl   = s3_y_in[19:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_rdy) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_rdy) begin
         s3_kind_ff     <= s2_kind_ff;
         s3_use_div_ff  <= s3_use_div_in;
         s3_fixed_ms_ff <= s3_fixed_ms_in;
         s3_y_ff        <= s3_y_in;
         s3_pp_hh_ff    <= 40'(s3_yh) * 40'(RECIP_125[39:20]);
         s3_pp_hl_ff    <= 40'(s3_yh) * 40'(RECIP_125[19:0]);
         s3_pp_lh_ff    <= 40'(s3_yl) * 40'(RECIP_125[39:20]);
         s3_pp_ll_ff    <= 40'(s3_yl) * 40'(RECIP_125[19:0]);
      end
   end

   // sum partial products into the quotient estimate
   assign s4_mid = {1'b0, s3_pp_hl_ff} + {1'b0, s3_pp_lh_ff};
   assign s4_sum = {s3_pp_hh_ff, 40'b0} + {19'b0, s4_mid, 20'b0} + {40'b0, s3_pp_ll_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_rdy) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_rdy) begin
         s4_kind_ff     <= s3_kind_ff;
         s4_use_div_ff  <= s3_use_div_ff;
         s4_fixed_ms_ff <= s3_fixed_ms_ff;
         s4_y_ff        <= s3_y_ff;
         s4_q_ff        <= s4_sum[77:46];
      end
   end

   // correct the estimate by one and build the result
   assign rs_qx125 = {1'b0, s4_q_ff, 7'b0} - {6'b0, s4_q_ff, 2'b0} + {8'b0, s4_q_ff};
   assign rs_rem   = {1'b0, s4_y_ff} - rs_qx125;
   assign rs_q     = (rs_rem >= {33'b0, DIV_125}) ? s4_q_ff + 32'd1 : s4_q_ff;

   always_comb begin
      rsp_data_in.do_publish = s4_kind_ff == KIND_PUBLISH;
      rsp_data_in.do_block   = s4_kind_ff == KIND_BLOCK;
      rsp_data_in.wait_ms    = s4_use_div_ff ? rs_q : s4_fixed_ms_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_rdy) begin
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_rdy) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: rtl/core/pis_checker.sv
// Port-level checks of the publish interval scheduler and their binding.
`include "publish_interval_scheduler_defines.svh"

module pis_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pis_pkg::rsp_type rsp_data
);
   import pis_pkg::*;

   `PIS_ASSERT_NEXT(a_reset_clears_rsp, clock, reset, !rsp_valid)
   `PIS_ASSERT_IMPL(a_stall_needs_full_rsp, clock, reset, !req_ready, rsp_valid && !rsp_ready)
   `PIS_ASSERT_IMPL(a_flags_exclusive, clock, reset, rsp_valid, !(rsp_data.do_publish && rsp_data.do_block))
   `PIS_ASSERT_IMPL(a_flag_zero_wait, clock, reset, rsp_valid && (rsp_data.do_publish || rsp_data.do_block), rsp_data.wait_ms == '0)

endmodule

bind publish_interval_scheduler pis_checker u_pis_checker (.*);

// File: verif/tb_top.sv
// Self-checking testbench of the publish interval scheduler with its own schedule predictor.
module tb_top;
   import pis_pkg::*;

   localparam bit [63:0] TIME_LIMIT = {1'b0, TIME_MAX};
   localparam bit [63:0] US_IN_MS   = 64'(US_PER_MS);
   localparam bit [63:0] US_IN_S    = 64'(US_PER_S);
   localparam bit [63:0] OFFLINE_MS = 64'd1000;
   localparam int        RX_HOLD    = 300;
   localparam int        SETTLE     = 12;

   logic      clock       = 1'b0;
   logic      reset       = 1'b1;
   logic      req_valid   = 1'b0;
   logic      req_ready;
   req_type   req_data    = '0;
   logic      rsp_valid;
   logic      rsp_ready   = 1'b0;
   rsp_type   rsp_data;
   logic      csr_wr_en   = 1'b0;
   logic [22:0] csr_wr_data = '0;

   publish_interval_scheduler u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_type     pending_events[$];
   rsp_type     awaited_actions[$];
   int unsigned queued_count    = 0;
   int unsigned accepted_count  = 0;
   int unsigned mismatch_count  = 0;
   bit          req_taken       = 1'b0;
   bit          quiet           = 1'b0;
   int          tx_gap          = 0;
   int          rx_gap          = 0;
   int          rx_hold         = 0;
   int          rx_hold_token   = 0;
   int          rx_hold_seen    = 0;
   bit [63:0]   cursor_us       = 0;

   // schedule predictor state
   bit [63:0]   sched_last_pub;
   bit [63:0]   sched_retry;
   bit          sched_manual;
   bit [22:0]   sched_interval;

   function automatic bit [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic bit [63:0] add_sat(bit [63:0] a, bit [63:0] b);
      bit [63:0] s;
      s = a + b;
      return (s > TIME_LIMIT) ? TIME_LIMIT : s;
   endfunction

   function automatic bit [31:0] span_to_ms(bit [63:0] span_us);
      bit [63:0] q;
      if (span_us == 0) return IDLE_WAIT_MS;
      q = span_us / US_IN_MS;
      return (q > 64'(WAIT_MS_MAX)) ? WAIT_MS_MAX : q[31:0];
   endfunction

   function automatic void push_retry(bit [63:0] now, bit [63:0] ms);
      bit [63:0] cand;
      cand = add_sat(now, ms * US_IN_MS);
      if (cand > sched_retry) sched_retry = cand;
   endfunction

   function automatic bit [31:0] wait_until(bit [63:0] now, bit [63:0] target);
      bit [63:0] eff;
      eff = target;
      if (sched_retry > now && sched_retry > eff) eff = sched_retry;
      if (eff <= now) return IDLE_WAIT_MS;
      return span_to_ms(eff - now);
   endfunction

   function automatic bit schedule_event(input req_type ev, output rsp_type act);
      bit [63:0] now;
      bit [63:0] iv_us;
      bit [63:0] next_due;
      bit        due;
      now = {1'b0, ev.now_time_us};
      act = '0;
      act.wait_ms = IDLE_WAIT_MS;
      case (ev.opcode)
         OP_REQUEST: begin
            sched_manual = 1'b1;
            return 1'b0;
         end
         OP_DONE: begin
            sched_last_pub = now;
            sched_retry = 0;
            sched_manual = 1'b0;
            return 1'b0;
         end
         OP_DELAY: begin
            push_retry(now, 64'(ev.backoff_ms));
            return 1'b0;
         end
         default: ;
      endcase
      if (!ev.link_up) begin
         push_retry(now, OFFLINE_MS);
         act.wait_ms = wait_until(now, add_sat(now, 64'(OFFLINE_US)));
         return 1'b1;
      end
      iv_us = 64'(sched_interval) * US_IN_S;
      if (sched_interval == 0 && !sched_manual) begin
         act.do_block = 1'b1;
         act.wait_ms = 0;
         return 1'b1;
      end
      due = sched_manual;
      next_due = now;
      if (!due && sched_interval != 0) begin
         if (sched_last_pub == 0) begin
            due = 1'b1;
         end else begin
            next_due = add_sat(sched_last_pub, iv_us);
            if (now >= next_due) due = 1'b1;
         end
      end
      if (!due) begin
         act.wait_ms = wait_until(now, next_due);
         return 1'b1;
      end
      if (sched_retry > now && !sched_manual) begin
         act.wait_ms = span_to_ms(sched_retry - now);
         return 1'b1;
      end
      sched_manual = 1'b0;
      act.do_publish = 1'b1;
      act.wait_ms = 0;
      return 1'b1;
   endfunction

   // driver: new item only when the line is free or the last one transferred
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (tx_gap != 0) begin
            tx_gap--;
            req_valid <= 1'b0;
         end else if (pending_events.size() != 0) begin
            req_data <= pending_events.pop_front();
            req_valid <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0) tx_gap = $urandom_range(1, 13);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (rx_hold_token != rx_hold_seen) begin
         rx_hold_seen = rx_hold_token;
         rx_hold = RX_HOLD;
      end
      if (rx_hold != 0) begin
         rx_hold--;
         rsp_ready <= 1'b0;
      end else if (rx_gap != 0) begin
         rx_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (!quiet && $urandom_range(0, 7) == 0) rx_gap = $urandom_range(1, 13);
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      rsp_type act;
      rsp_type want;
      req_taken <= req_valid && req_ready;
      if (reset) begin
         sched_last_pub = 0;
         sched_retry = 0;
         sched_manual = 1'b0;
         sched_interval = 0;
      end else begin
         if (csr_wr_en) sched_interval = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            if (awaited_actions.size() == 0) begin
               $error("result transfer with nothing expected: wait_ms actual %0d",
                      rsp_data.wait_ms);
               mismatch_count++;
            end else begin
               want = awaited_actions.pop_front();
               if (rsp_data.do_publish !== want.do_publish) begin
                  $error("do_publish expected %0d actual %0d", want.do_publish,
                         rsp_data.do_publish);
                  mismatch_count++;
               end
               if (rsp_data.do_block !== want.do_block) begin
                  $error("do_block expected %0d actual %0d", want.do_block,
                         rsp_data.do_block);
                  mismatch_count++;
               end
               if (rsp_data.wait_ms !== want.wait_ms) begin
                  $error("wait_ms expected %0d actual %0d", want.wait_ms, rsp_data.wait_ms);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            accepted_count++;
            if (schedule_event(req_data, act)) awaited_actions.push_back(act);
         end
      end
   end

   task automatic queue_event(opcode_type op, bit [63:0] now, bit [31:0] dly, bit link);
      req_type ev;
      ev.opcode = op;
      ev.now_time_us = now[62:0];
      ev.backoff_ms = dly;
      ev.link_up = link;
      pending_events.push_back(ev);
      queued_count++;
   endtask

   task automatic drain();
      do @(negedge clock);
      while (accepted_count != queued_count || awaited_actions.size() != 0);
   endtask

   task automatic write_interval(bit [22:0] value);
      drain();
      repeat (SETTLE) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_random(int unsigned count, bit [22:0] iv);
      bit [63:0] span_us;
      bit [63:0] step;
      bit [31:0] dly;
      bit        link;
      int unsigned pick;
      span_us = (iv == 0) ? 64'd2000000 : 64'(iv) * US_IN_S;
      for (int unsigned i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0: step = 0;
            1, 2, 3: step = 64'($urandom_range(0, 2000));
            4, 5, 6, 7: step = rand64() % (2 * span_us + 1);
            8: step = rand64() % 64'd5000000;
            default: begin
               step = 0;
               case ($urandom_range(0, 2))
                  0: cursor_us = rand64() & TIME_LIMIT;
                  1: cursor_us = TIME_LIMIT - 64'($urandom_range(0, 3000000));
                  default: cursor_us = 64'($urandom_range(0, 1000));
               endcase
            end
         endcase
         cursor_us = cursor_us + step;
         if (cursor_us > TIME_LIMIT) cursor_us = TIME_LIMIT;
         case ($urandom_range(0, 3))
            0: dly = $urandom_range(0, 3000);
            1: dly = $urandom;
            2: dly = WAIT_MS_MAX;
            default: dly = $urandom_range(0, 20000);
         endcase
         link = ($urandom_range(0, 99) < 85);
         pick = $urandom_range(0, 99);
         if (pick < 45) queue_event(OP_QUERY, cursor_us, dly, link);
         else if (pick < 60) queue_event(OP_DONE, cursor_us, dly, link);
         else if (pick < 75) queue_event(OP_DELAY, cursor_us, dly, link);
         else if (pick < 88) queue_event(OP_REQUEST, cursor_us, dly, link);
         else queue_event(opcode_type'($urandom_range(0, 3)), rand64(), $urandom,
                          1'($urandom));
      end
   endtask

   initial begin
      bit [22:0] phase_iv[9];
      phase_iv = '{23'd1, 23'd2, 23'd0, 23'd4294967, 23'h7FFFFF, 23'd0, 23'd3, 23'd0, 23'd1};
      phase_iv[5] = 23'($urandom_range(0, 23'h7FFFFF));
      phase_iv[7] = 23'($urandom_range(1, 10));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // interval disabled: block, manual publish, offline back-off, saturated time
      queue_event(OP_QUERY, 100, 0, 1'b1);
      queue_event(OP_REQUEST, 200, 0, 1'b1);
      queue_event(OP_QUERY, 300, 0, 1'b1);
      queue_event(OP_QUERY, 400, 0, 1'b0);
      queue_event(OP_QUERY, TIME_LIMIT, '1, 1'b0);
      queue_event(OP_DONE, 0, 0, 1'b1);
      queue_event(OP_DELAY, 5, WAIT_MS_MAX, 1'b1);
      queue_event(OP_REQUEST, 6, 0, 1'b1);
      queue_event(OP_QUERY, 7, 0, 1'b1);

      // one-second interval: first publish, sub-millisecond wait, retry hold-off
      write_interval(23'd1);
      queue_event(OP_QUERY, 10, 0, 1'b1);
      queue_event(OP_DONE, 1000, 0, 1'b1);
      queue_event(OP_QUERY, 1000500, 0, 1'b1);
      queue_event(OP_QUERY, 2001000, 0, 1'b1);
      queue_event(OP_DELAY, 2001000, 10, 1'b1);
      queue_event(OP_QUERY, 2005000, 0, 1'b1);
      queue_event(OP_DONE, TIME_LIMIT - 10, 0, 1'b1);
      queue_event(OP_QUERY, TIME_LIMIT - 5, 0, 1'b1);
      queue_event(OP_QUERY, TIME_LIMIT, 0, 1'b1);

      // widest interval: saturated wait
      write_interval(23'h7FFFFF);
      queue_event(OP_DONE, 1, 0, 1'b1);
      queue_event(OP_QUERY, 2, 0, 1'b1);
      queue_event(OP_DELAY, 2, 0, 1'b1);
      queue_event(OP_QUERY, 3, 0, 1'b0);

      for (int p = 0; p < 9; p++) begin
         write_interval(phase_iv[p]);
         if (p == 8) quiet = 1'b1;
         if (p == 0) rx_hold_token++;
         queue_random(190, phase_iv[p]);
      end

      drain();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
